FILE: src/lmfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared types and constants of the led matrix frame buffer.
// ----------------------------------------------------------------------------
package lmfb_pkg;

  localparam int PLANE_ROWS = 8;
  localparam int ROW_SEL_W  = $clog2(PLANE_ROWS);
  localparam int BYTE_W     = 8;
  localparam int LINE_W     = PLANE_ROWS * BYTE_W;
  localparam int POS_W      = 6;
  localparam int DIGIT_W    = 4;
  localparam int COORD_W    = 8;
  localparam int RSEL_W     = 5;
  localparam int ACT_W      = 3;
  localparam int CALC_W     = 13;

  typedef enum logic [ACT_W-1:0] {
    ACT_PIXEL   = 3'd0,
    ACT_ROW     = 3'd1,
    ACT_BLOCK   = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_DISPLAY = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_op_e;

  // one queued command; writes carry a bit mask over the whole block line
  typedef struct packed {
    cmd_op_e           op;
    logic [POS_W-1:0]  pos;
    logic [LINE_W-1:0] mask;
    logic [LINE_W-1:0] data;
  } cmd_t;

endpackage

FILE: src/led_matrix_frame_buffer.sv
// a write action reads its line on leaving idle, then merges and writes it back in the merge state
// clear drops all line valid bits at once; display reads each byte in ST_DRD, then loads it in ST_DWR
// the first display byte passes the queue, the ST_DRD read and the ST_DWR load; the store port sets the pace
// a two-entry command queue lets actions be taken while the store is busy
// reset clears per-line valid bits at once; no clearing pass is needed
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer
// Frame buffer for a grid of 8x8 LED blocks with pixel, row, block, clear
// and display actions.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer import lmfb_pkg::*; #(
  parameter int BLOCKS_X = 4,
  parameter int BLOCKS_Y = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [COORD_W-1:0] x_coord_i,
  input  logic [COORD_W-1:0] y_coord_i,
  input  logic               pixel_on_i,
  input  logic [RSEL_W-1:0]  row_select_i,
  input  logic [BYTE_W-1:0]  row_byte_i,
  input  logic [LINE_W-1:0]  tile_bytes_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DIGIT_W-1:0] digit_row_o,
  output logic [POS_W-1:0]   block_index_o,
  output logic [BYTE_W-1:0]  row_data_o,
  output logic               last_o
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t push_cmd, head_cmd;

  lmfb_front #(
    .BLOCKS_X (BLOCKS_X),
    .BLOCKS_Y (BLOCKS_Y)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .pixel_on_i   (pixel_on_i),
    .row_select_i (row_select_i),
    .row_byte_i   (row_byte_i),
    .tile_bytes_i (tile_bytes_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  lmfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  lmfb_back #(
    .BLOCKS_X (BLOCKS_X),
    .BLOCKS_Y (BLOCKS_Y)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_row_o   (digit_row_o),
    .block_index_o (block_index_o),
    .row_data_o    (row_data_o),
    .last_o        (last_o)
  );

endmodule

FILE: src/lmfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_front
// Accepts actions, range checks them and turns them into queued commands.
// ----------------------------------------------------------------------------
module lmfb_front import lmfb_pkg::*; #(
  parameter int BLOCKS_X = 4,
  parameter int BLOCKS_Y = 2
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [COORD_W-1:0] x_coord_i,
  input  logic [COORD_W-1:0] y_coord_i,
  input  logic               pixel_on_i,
  input  logic [RSEL_W-1:0]  row_select_i,
  input  logic [BYTE_W-1:0]  row_byte_i,
  input  logic [LINE_W-1:0]  tile_bytes_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cmd_t               q_cmd_o
);

  localparam logic signed [CALC_W-1:0] BX_S   = CALC_W'(BLOCKS_X);
  localparam logic signed [CALC_W-1:0] BYM1_S = CALC_W'(BLOCKS_Y - 1);
  localparam logic signed [CALC_W-1:0] BC_S   = CALC_W'(BLOCKS_X * BLOCKS_Y);
  localparam logic signed [CALC_W-1:0] XMAX_S = CALC_W'(BLOCKS_X * 8);
  localparam logic signed [CALC_W-1:0] YMAX_S = CALC_W'(BLOCKS_Y * 8);

  logic signed [CALC_W-1:0] xs, ys, xb, yb, pos;
  logic                     pix_ok, pos_ok, rsel_ok, useful;
  logic [POS_W-1:0]         pix_bit;
  logic [ROW_SEL_W+2:0]     row_shift;
  action_e                  act;

  assign act = action_e'(action_i);
  assign xs  = CALC_W'(signed'(x_coord_i));
  assign ys  = CALC_W'(signed'(y_coord_i));

  assign pix_ok  = (xs >= 0) && (xs < XMAX_S) && (ys >= 0) && (ys < YMAX_S);
  assign rsel_ok = !row_select_i[RSEL_W-1] && !row_select_i[RSEL_W-2];

  // pixel writes address by block, row and block writes by the raw coordinates
  assign xb  = (act == ACT_PIXEL) ? CALC_W'(x_coord_i[COORD_W-1:3]) : xs;
  assign yb  = (act == ACT_PIXEL) ? CALC_W'(y_coord_i[COORD_W-1:3]) : ys;
  assign pos = (BYM1_S - yb) * BX_S + xb;
  assign pos_ok = (pos >= 0) && (pos < BC_S);

  assign pix_bit   = {y_coord_i[2:0], ~x_coord_i[2:0]};
  assign row_shift = {row_select_i[ROW_SEL_W-1:0], 3'b000};

  always_comb begin
    q_cmd_o      = '0;
    q_cmd_o.pos  = pos[POS_W-1:0];
    useful       = 1'b0;
    case (act)
      ACT_PIXEL: begin
        useful       = pix_ok && pos_ok;
        q_cmd_o.op   = CMD_WRITE;
        q_cmd_o.mask = LINE_W'(1) << pix_bit;
        q_cmd_o.data = pixel_on_i ? (LINE_W'(1) << pix_bit) : '0;
      end
      ACT_ROW: begin
        useful       = rsel_ok && pos_ok;
        q_cmd_o.op   = CMD_WRITE;
        q_cmd_o.mask = LINE_W'({BYTE_W{1'b1}}) << row_shift;
        q_cmd_o.data = LINE_W'(row_byte_i) << row_shift;
      end
      ACT_BLOCK: begin
        useful       = pos_ok;
        q_cmd_o.op   = CMD_WRITE;
        q_cmd_o.mask = '1;
        q_cmd_o.data = tile_bytes_i;
      end
      ACT_CLEAR: begin
        useful     = 1'b1;
        q_cmd_o.op = CMD_CLEAR;
      end
      ACT_DISPLAY: begin
        useful     = 1'b1;
        q_cmd_o.op = CMD_DISPLAY;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  // dropped actions are taken but never queued
  assign q_push_o   = in_valid_i && !q_full_i && useful;

endmodule

FILE: src/lmfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module lmfb_queue import lmfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  cmd_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slots_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/lmfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_back
// Executes queued commands on the block store and streams display bytes.
// ----------------------------------------------------------------------------
module lmfb_back import lmfb_pkg::*; #(
  parameter int BLOCKS_X = 4,
  parameter int BLOCKS_Y = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  cmd_t                q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DIGIT_W-1:0]  digit_row_o,
  output logic [POS_W-1:0]    block_index_o,
  output logic [BYTE_W-1:0]   row_data_o,
  output logic                last_o
);

  localparam int BC = BLOCKS_X * BLOCKS_Y;
  localparam int AW = (BC > 1) ? $clog2(BC) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MERGE = 4'b0010,
    ST_DRD   = 4'b0100,
    ST_DWR   = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [LINE_W-1:0]      mem [BC];
  logic [BC-1:0]          vld_q, vld_d;
  logic [LINE_W-1:0]      rdata_q, rd_line, wdata;
  logic                   rvalid_q;
  logic                   rd_en, wr_en, clr;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          pos_q, pos_d;
  logic [LINE_W-1:0]      mask_q, mask_d, data_q, data_d;
  logic [ROW_SEL_W-1:0]   r_q, r_d;
  logic [AW-1:0]          b_q, b_d;
  logic                   run_last;
  logic                   ovalid_q, ovalid_d, oload;
  logic [DIGIT_W-1:0]     odigit_q;
  logic [POS_W-1:0]       oindex_q;
  logic [BYTE_W-1:0]      odata_q;
  logic                   olast_q;

  // lines never written since reset or clear read as zero
  assign rd_line  = rvalid_q ? rdata_q : '0;
  assign wdata    = (rd_line & ~mask_q) | (data_q & mask_q);
  assign run_last = (r_q == ROW_SEL_W'(PLANE_ROWS - 1)) && (b_q == AW'(BC - 1));
  assign rd_addr  = (state_q == ST_IDLE) ? q_cmd_i.pos[AW-1:0] : b_q;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    clr     = 1'b0;
    oload   = 1'b0;
    pos_d   = pos_q;
    mask_d  = mask_q;
    data_d  = data_q;
    r_d     = r_q;
    b_d     = b_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            CMD_WRITE: begin
              rd_en   = 1'b1;
              pos_d   = q_cmd_i.pos[AW-1:0];
              mask_d  = q_cmd_i.mask;
              data_d  = q_cmd_i.data;
              state_d = ST_MERGE;
            end
            CMD_CLEAR: begin
              clr = 1'b1;
            end
            CMD_DISPLAY: begin
              r_d     = '0;
              b_d     = '0;
              state_d = ST_DRD;
            end
            default: begin
              clr = 1'b0;
            end
          endcase
        end
      end
      ST_MERGE: begin
        wr_en   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DRD: begin
        // read only once the output slot is sure to be free next cycle
        if (!ovalid_q || !out_stall_i) begin
          rd_en   = 1'b1;
          state_d = ST_DWR;
        end
      end
      ST_DWR: begin
        oload = 1'b1;
        if (run_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DRD;
          if (b_q == AW'(BC - 1)) begin
            b_d = '0;
            r_d = r_q + 1'b1;
          end else begin
            b_d = b_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (clr) begin
      vld_d = '0;
    end else if (wr_en) begin
      vld_d[pos_q] = 1'b1;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (oload) begin
      ovalid_d = 1'b1;
    end else if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      vld_q    <= '0;
      ovalid_q <= 1'b0;
      r_q      <= '0;
      b_q      <= '0;
    end else begin
      state_q  <= state_d;
      vld_q    <= vld_d;
      ovalid_q <= ovalid_d;
      r_q      <= r_d;
      b_q      <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    mask_q <= mask_d;
    data_q <= data_d;
    if (oload) begin
      odigit_q <= DIGIT_W'(r_q) + DIGIT_W'(1);
      oindex_q <= POS_W'(b_q);
      odata_q  <= rd_line[{r_q, 3'b000} +: BYTE_W];
      olast_q  <= run_last;
    end
  end

  // block store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q  <= mem[rd_addr];
      rvalid_q <= vld_q[rd_addr];
    end
  end

  assign out_valid_o   = ovalid_q;
  assign digit_row_o   = odigit_q;
  assign block_index_o = oindex_q;
  assign row_data_o    = odata_q;
  assign last_o        = olast_q;

  a_out_from_dwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_DWR))
    else $error("display byte appeared without a store read");

  a_merge_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> $past(state_q == ST_IDLE))
    else $error("merge without a preceding read issue");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (vld_q == '0))
    else $error("clear left stale lines valid");

  a_last_on_top_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> (odigit_q == DIGIT_W'(PLANE_ROWS)))
    else $error("last flag outside the final row plane");

  a_dwr_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DWR) |-> !ovalid_q)
    else $error("display byte would overwrite a pending transfer");

endmodule

FILE: verif/led_matrix_frame_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer_test
// Self-checking bench for the led matrix frame buffer. A queue of actions
// (directed corner cases, then random traffic) feeds the input channel; an
// internal copy of the row planes predicts every display byte, and each
// output transfer is compared field by field in order. Both sides idle at
// random, and the output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_test;
  import lmfb_pkg::*;

  localparam int BLOCKS_X  = 4;
  localparam int BLOCKS_Y  = 2;
  localparam int BLOCK_CNT = BLOCKS_X * BLOCKS_Y;
  localparam logic [ACT_W-1:0] ACT_SPARE = ACT_W'(ACT_DISPLAY + 1);
  localparam int DIRECTED_CNT = 25;
  localparam int ITEM_CNT     = 330;
  localparam int HOLD_START   = 234;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               pixel_on;
    logic [RSEL_W-1:0]  row_select;
    logic [BYTE_W-1:0]  row_byte;
    logic [LINE_W-1:0]  tile_bytes;
  } frame_cmd_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_row;
    logic [POS_W-1:0]   block_index;
    logic [BYTE_W-1:0]  row_data;
    logic               last;
  } disp_byte_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [ACT_W-1:0]   action_i     = ACT_CLEAR;
  logic [COORD_W-1:0] x_coord_i    = '0;
  logic [COORD_W-1:0] y_coord_i    = '0;
  logic               pixel_on_i   = 1'b0;
  logic [RSEL_W-1:0]  row_select_i = '0;
  logic [BYTE_W-1:0]  row_byte_i   = '0;
  logic [LINE_W-1:0]  tile_bytes_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [DIGIT_W-1:0] digit_row_o;
  logic [POS_W-1:0]   block_index_o;
  logic [BYTE_W-1:0]  row_data_o;
  logic               last_o;

  frame_cmd_t  pending_q[$];
  disp_byte_t  display_q[$];
  logic [BYTE_W-1:0] planes [PLANE_ROWS][BLOCK_CNT];
  logic hold_out     = 1'b0;
  int   items_taken  = 0;
  int   display_runs = 0;
  int   bytes_seen   = 0;
  int   mismatches   = 0;

  led_matrix_frame_buffer #(
    .BLOCKS_X(BLOCKS_X),
    .BLOCKS_Y(BLOCKS_Y)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .pixel_on_i   (pixel_on_i),
    .row_select_i (row_select_i),
    .row_byte_i   (row_byte_i),
    .tile_bytes_i (tile_bytes_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_row_o  (digit_row_o),
    .block_index_o(block_index_o),
    .row_data_o   (row_data_o),
    .last_o       (last_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // idling: receiver-heavy gaps, then sender-heavy, then none
  function automatic int idle_pct(bit sender);
    if (items_taken < 110) return sender ? 27 : 68;
    if (items_taken < 220) return sender ? 68 : 27;
    return 0;
  endfunction

  function automatic int tile_pos(int bx, int by);
    int pos;
    pos = (BLOCKS_Y - 1 - by) * BLOCKS_X + bx;
    return (pos < 0 || pos >= BLOCK_CNT) ? -1 : pos;
  endfunction

  task automatic apply_action(input frame_cmd_t c);
    int px, py, rsel, pos;
    disp_byte_t d;
    px   = $signed(c.x_coord);
    py   = $signed(c.y_coord);
    rsel = $signed(c.row_select);
    case (c.action)
      ACT_PIXEL: begin
        if (px >= 0 && px < BLOCKS_X * 8 && py >= 0 && py < BLOCKS_Y * 8) begin
          pos = tile_pos(px / 8, py / 8);
          if (pos >= 0) planes[py % 8][pos][7 - px % 8] = c.pixel_on;
        end
      end
      ACT_ROW: begin
        pos = tile_pos(px, py);
        if (rsel >= 0 && rsel < PLANE_ROWS && pos >= 0)
          planes[rsel][pos] = c.row_byte;
      end
      ACT_BLOCK: begin
        pos = tile_pos(px, py);
        if (pos >= 0)
          for (int r = 0; r < PLANE_ROWS; r++)
            planes[r][pos] = c.tile_bytes[r*BYTE_W +: BYTE_W];
      end
      ACT_CLEAR: begin
        for (int r = 0; r < PLANE_ROWS; r++)
          for (int b = 0; b < BLOCK_CNT; b++) planes[r][b] = '0;
      end
      ACT_DISPLAY: begin
        display_runs++;
        for (int r = 0; r < PLANE_ROWS; r++)
          for (int b = 0; b < BLOCK_CNT; b++) begin
            d.digit_row   = DIGIT_W'(r + 1);
            d.block_index = POS_W'(b);
            d.row_data    = planes[r][b];
            d.last        = (r == PLANE_ROWS - 1 && b == BLOCK_CNT - 1);
            display_q.push_back(d);
          end
      end
      default: ;
    endcase
  endtask

  function automatic int compare_byte(disp_byte_t e, disp_byte_t g);
    int n;
    n = 0;
    if (g.digit_row !== e.digit_row) begin
      n++;
      $display("%0t: digit_row expected %0d got %0d", $time, e.digit_row, g.digit_row);
    end
    if (g.block_index !== e.block_index) begin
      n++;
      $display("%0t: block_index expected %0d got %0d", $time, e.block_index,
               g.block_index);
    end
    if (g.row_data !== e.row_data) begin
      n++;
      $display("%0t: row_data expected %h got %h", $time, e.row_data, g.row_data);
    end
    if (g.last !== e.last) begin
      n++;
      $display("%0t: last expected %b got %b", $time, e.last, g.last);
    end
    return n;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        action_i     <= pending_q[0].action;
        x_coord_i    <= pending_q[0].x_coord;
        y_coord_i    <= pending_q[0].y_coord;
        pixel_on_i   <= pending_q[0].pixel_on;
        row_select_i <= pending_q[0].row_select;
        row_byte_i   <= pending_q[0].row_byte;
        tile_bytes_i <= pending_q[0].tile_bytes;
        in_valid_i   <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: output checked before the input transfer of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      for (int r = 0; r < PLANE_ROWS; r++)
        for (int b = 0; b < BLOCK_CNT; b++) planes[r][b] = '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        bytes_seen <= bytes_seen + 1;
        if (display_q.size() == 0) begin
          $display("%0t: expected no byte, got row %0d block %0d data %h last %b", $time,
                   digit_row_o, block_index_o, row_data_o, last_o);
          mismatches <= mismatches + 1;
        end else begin
          mismatches <= mismatches + compare_byte(display_q.pop_front(),
                                                  {digit_row_o, block_index_o, row_data_o, last_o});
        end
      end
      if (in_valid_i && !in_stall_o) begin
        apply_action({action_i, x_coord_i, y_coord_i, pixel_on_i, row_select_i, row_byte_i,
                      tile_bytes_i});
        items_taken <= items_taken + 1;
      end
      out_stall_i <= hold_out || ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  task automatic push_cmd(logic [ACT_W-1:0] act, int x, int y, bit on, int rsel, int rbyte,
                          logic [LINE_W-1:0] rows);
    frame_cmd_t c;
    c.action     = act;
    c.x_coord    = COORD_W'(x);
    c.y_coord    = COORD_W'(y);
    c.pixel_on   = on;
    c.row_select = RSEL_W'(rsel);
    c.row_byte   = BYTE_W'(rbyte);
    c.tile_bytes = rows;
    pending_q.push_back(c);
  endtask

  function automatic int pick_coord(int lim);
    if ($urandom_range(9) == 0) return $signed(8'($urandom));
    return $urandom_range(lim + 1) - 1;
  endfunction

  function automatic frame_cmd_t random_cmd(int idx);
    frame_cmd_t c;
    int pick;
    c.x_coord    = COORD_W'($urandom);
    c.y_coord    = COORD_W'($urandom);
    c.pixel_on   = 1'($urandom);
    c.row_select = RSEL_W'($urandom);
    c.row_byte   = BYTE_W'($urandom);
    c.tile_bytes = {$urandom, $urandom};
    pick = $urandom_range(99);
    // a run of displays while the output is held off
    if (idx >= HOLD_START - 2 && idx < HOLD_START + 14 && idx % 2 == 0) pick = 80;
    if (pick < 32) begin
      c.action  = ACT_PIXEL;
      c.x_coord = COORD_W'(pick_coord(BLOCKS_X * 8));
      c.y_coord = COORD_W'(pick_coord(BLOCKS_Y * 8));
    end else if (pick < 54) begin
      c.action  = ACT_ROW;
      c.x_coord = COORD_W'(pick_coord(BLOCKS_X));
      c.y_coord = COORD_W'(pick_coord(BLOCKS_Y));
      if ($urandom_range(7) != 0) c.row_select = RSEL_W'($urandom_range(PLANE_ROWS - 1));
    end else if (pick < 70) begin
      c.action  = ACT_BLOCK;
      c.x_coord = COORD_W'(pick_coord(BLOCKS_X));
      c.y_coord = COORD_W'(pick_coord(BLOCKS_Y));
    end else if (pick < 75) begin
      c.action = ACT_CLEAR;
    end else if (pick < 86) begin
      c.action = ACT_DISPLAY;
    end else if (pick < 93) begin
      c.action = ACT_W'(ACT_SPARE + $urandom_range(2));
    end else begin
      c.action = ACT_PIXEL;
    end
    return c;
  endfunction

  initial begin
    push_cmd(ACT_DISPLAY, 0, 0, 1'b0, 0, 0, '0);
    push_cmd(ACT_PIXEL, 0, 0, 1'b1, 0, 0, '0);
    push_cmd(ACT_PIXEL, BLOCKS_X * 8 - 1, BLOCKS_Y * 8 - 1, 1'b1, 0, 0, '0);
    push_cmd(ACT_PIXEL, 7, 8, 1'b1, 0, 0, '1);
    push_cmd(ACT_PIXEL, BLOCKS_X * 8, 0, 1'b1, 0, 0, '0);
    push_cmd(ACT_PIXEL, -1, 3, 1'b1, 0, 0, '0);
    push_cmd(ACT_PIXEL, 5, BLOCKS_Y * 8, 1'b1, 0, 0, '0);
    push_cmd(ACT_PIXEL, -128, 127, 1'b1, 0, 0, '0);
    push_cmd(ACT_PIXEL, 0, 0, 1'b0, 0, 0, '0);
    push_cmd(ACT_ROW, 0, 0, 1'b0, 0, 8'ha5, '0);
    push_cmd(ACT_ROW, BLOCKS_X - 1, BLOCKS_Y - 1, 1'b0, PLANE_ROWS - 1, 8'hff, '0);
    push_cmd(ACT_ROW, 1, 0, 1'b0, -8, 8'h11, '0);
    push_cmd(ACT_ROW, 1, 0, 1'b0, -1, 8'h22, '0);
    push_cmd(ACT_ROW, 1, 0, 1'b0, PLANE_ROWS, 8'h33, '0);
    push_cmd(ACT_ROW, 1, 0, 1'b0, 15, 8'h44, '0);
    // coordinates out of range on their own but giving a valid offset
    push_cmd(ACT_ROW, BLOCKS_X + 1, BLOCKS_Y - 1, 1'b0, 3, 8'h3c, '0);
    push_cmd(ACT_ROW, -1, 0, 1'b0, 2, 8'h81, '0);
    push_cmd(ACT_BLOCK, 1, 0, 1'b1, 31, 8'hff, 64'h0123_4567_89ab_cdef);
    push_cmd(ACT_BLOCK, 0, BLOCKS_Y, 1'b1, 0, 0, '1);
    push_cmd(ACT_BLOCK, 127, -128, 1'b0, 0, 0, '1);
    push_cmd(ACT_DISPLAY, 0, 0, 1'b0, 0, 0, '0);
    push_cmd(ACT_SPARE, 2, 1, 1'b1, 3, 8'hff, '1);
    push_cmd(ACT_W'(ACT_SPARE + 1), 0, 0, 1'b0, 0, 0, '0);
    push_cmd(ACT_W'(ACT_SPARE + 2), 1, 1, 1'b1, 1, 8'h0f, '1);
    push_cmd(ACT_CLEAR, 0, 0, 1'b0, 0, 0, '0);
    for (int i = DIRECTED_CNT; i < ITEM_CNT; i++) pending_q.push_back(random_cmd(i));
    pending_q.push_back(random_cmd(HOLD_START));
  end

  // long output hold-off while the sender keeps offering displays
  initial begin
    wait (items_taken >= HOLD_START);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    wait (rst_ni);
    while (pending_q.size() != 0 || in_valid_i || display_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("tb: %0d actions transferred, %0d display runs, %0d bytes compared",
             items_taken, display_runs, bytes_seen);
    $display("tb: idling on both sides, one output hold-off of %0d cycles, %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && display_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
